@@ hw/rtl/pps_pkg.sv @@
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types and constants for the preemptive priority scheduler unit.
// ----------------------------------------------------------------------------
package pps_pkg;

  // default sizing of the job table and of time and priority values
  localparam int MAX_JOBS_DEF  = 8;
  localparam int TIME_BITS_DEF = 16;
  localparam int PRIO_BITS_DEF = 8;

  // widths of the request and result fields at the ports
  localparam int SLOT_IO_W = 3;
  localparam int TIME_IO_W = 16;
  localparam int PRIO_IO_W = 8;

  // request opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPD
  } pps_state_e;

  // control from the tick sequencer to the selection unit
  typedef struct packed {
    logic clear;
    logic cand_vld;
  } pps_sel_ctl_t;

endpackage

@@ hw/rtl/pps_select.sv @@
// ----------------------------------------------------------------------------
// pps_select
// Running best-candidate register for the per-tick scan of the job table.
// ----------------------------------------------------------------------------
module pps_select #(
  parameter int MAX_JOBS  = pps_pkg::MAX_JOBS_DEF,
  parameter int TIME_BITS = pps_pkg::TIME_BITS_DEF,
  parameter int PRIO_BITS = pps_pkg::PRIO_BITS_DEF,
  localparam int SLOT_W   = $clog2(MAX_JOBS)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pps_pkg::pps_sel_ctl_t ctl_i,
  input  logic [SLOT_W-1:0]    cand_slot_i,
  input  logic [PRIO_BITS-1:0] cand_prio_i,
  input  logic [TIME_BITS-1:0] cand_arr_i,
  input  logic [TIME_BITS-1:0] cand_len_i,
  input  logic [TIME_BITS-1:0] cand_rem_i,
  output logic                 found_o,
  output logic [SLOT_W-1:0]    best_slot_o,
  output logic [PRIO_BITS-1:0] best_prio_o,
  output logic [TIME_BITS-1:0] best_arr_o,
  output logic [TIME_BITS-1:0] best_len_o,
  output logic [TIME_BITS-1:0] best_rem_o
);
  import pps_pkg::*;

  logic                 found_q;
  logic [SLOT_W-1:0]    slot_q;
  logic [PRIO_BITS-1:0] prio_q;
  logic [TIME_BITS-1:0] arr_q, len_q, rem_q;
  logic                 better;
  logic                 take;

  // slots arrive in ascending order, so a full tie keeps the earlier slot
  assign better = (cand_prio_i < prio_q) ||
                  ((cand_prio_i == prio_q) && (cand_arr_i < arr_q));
  assign take   = ctl_i.cand_vld && (!found_q || better);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (ctl_i.clear) begin
      found_q <= 1'b0;
    end else if (take) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      slot_q <= cand_slot_i;
      prio_q <= cand_prio_i;
      arr_q  <= cand_arr_i;
      len_q  <= cand_len_i;
      rem_q  <= cand_rem_i;
    end
  end

  assign found_o     = found_q;
  assign best_slot_o = slot_q;
  assign best_prio_o = prio_q;
  assign best_arr_o  = arr_q;
  assign best_len_o  = len_q;
  assign best_rem_o  = rem_q;

endmodule

@@ hw/rtl/preemptive_priority_scheduler_unit.sv @@
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_unit
// Job table with a one-time-unit-per-tick preemptive priority scheduler.
// ----------------------------------------------------------------------------
// A load request writes a job into its slot and gives no result; a slot
// number at or above MAX_JOBS is dropped. No request is accepted while a
// tick is in progress: the job table sits in a synchronous memory with one
// read port, so the scan reads one slot per cycle, with the read data
// registered, then the update step writes the picked job back, or retires
// it once done, and loads the result register. A result that is not taken
// holds the next tick in its update step until the output register frees up.
module preemptive_priority_scheduler_unit #(
  parameter int MAX_JOBS  = pps_pkg::MAX_JOBS_DEF,
  parameter int TIME_BITS = pps_pkg::TIME_BITS_DEF,
  parameter int PRIO_BITS = pps_pkg::PRIO_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          opcode_i,
  input  logic [pps_pkg::SLOT_IO_W-1:0] job_slot_i,
  input  logic [pps_pkg::TIME_IO_W-1:0] arrival_time_i,
  input  logic [pps_pkg::TIME_IO_W-1:0] run_length_i,
  input  logic [pps_pkg::PRIO_IO_W-1:0] priority_level_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [pps_pkg::TIME_IO_W-1:0] slot_time_o,
  output logic                          busy_res_o,
  output logic [pps_pkg::SLOT_IO_W-1:0] running_job_o,
  output logic                          job_done_o,
  output logic [pps_pkg::TIME_IO_W-1:0] turnaround_o,
  output logic [pps_pkg::TIME_IO_W-1:0] waiting_o,
  output logic                          all_done_o
);
  import pps_pkg::*;

  localparam int SLOT_W = $clog2(MAX_JOBS);
  localparam int CNT_W  = $clog2(MAX_JOBS + 1);
  localparam int ENT_W  = 3 * TIME_BITS + PRIO_BITS;

  // entry layout: {priority, arrival, length, remaining}
  localparam int REM_LO = 0;
  localparam int LEN_LO = TIME_BITS;
  localparam int ARR_LO = 2 * TIME_BITS;
  localparam int PRI_LO = 3 * TIME_BITS;

  pps_state_e state_q, state_d;

  logic [ENT_W-1:0]     mem_q [MAX_JOBS];
  logic [ENT_W-1:0]     rd_data_q;
  logic                 mem_we;
  logic [SLOT_W-1:0]    mem_waddr;
  logic [ENT_W-1:0]     mem_wdata;

  logic [MAX_JOBS-1:0]  valid_q, adm_q, clr_vec, valid_after;
  logic [TIME_BITS-1:0] time_q, fin_time;
  logic [CNT_W-1:0]     idx_q;
  logic [SLOT_W-1:0]    rd_idx_q;
  logic                 rd_vld_q;

  logic                 in_acc, ld_go, tick_go, scan_issue, upd_go;
  logic [SLOT_W-1:0]    ld_slot;
  logic [TIME_BITS-1:0] ld_len, ld_rem;

  logic [PRIO_BITS-1:0] rd_prio;
  logic [TIME_BITS-1:0] rd_arr, rd_len, rd_rem;
  logic                 cand_elig;
  pps_sel_ctl_t         sel_ctl;

  logic                 found;
  logic [SLOT_W-1:0]    best_slot;
  logic [PRIO_BITS-1:0] best_prio;
  logic [TIME_BITS-1:0] best_arr, best_len, best_rem, rem_dec, turn, wait_t;
  logic                 done;

  logic                 out_valid_q;
  logic [TIME_IO_W-1:0] slot_time_q, turnaround_q, waiting_q;
  logic                 busy_q, job_done_q, all_done_q;
  logic [SLOT_IO_W-1:0] running_job_q;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    scan_issue = 1'b0;
    upd_go     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && (opcode_i == OP_TICK)) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (idx_q < CNT_W'(MAX_JOBS)) begin
          scan_issue = 1'b1;
        end else begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        if (!out_valid_q || out_ready_i) begin
          upd_go  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_acc  = in_valid_i && in_ready_o;
  assign tick_go = in_acc && (opcode_i == OP_TICK);
  assign ld_go   = in_acc && (opcode_i == OP_LOAD) && (32'(job_slot_i) < MAX_JOBS);
  assign ld_slot = SLOT_W'(job_slot_i);
  assign ld_len  = TIME_BITS'(run_length_i);
  // a zero run length still needs one time unit
  assign ld_rem  = (ld_len == '0) ? TIME_BITS'(1) : ld_len;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= scan_issue;
      if (tick_go) begin
        idx_q <= '0;
      end else if (scan_issue) begin
        idx_q <= idx_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_issue) begin
      rd_idx_q <= idx_q[SLOT_W-1:0];
    end
  end

  // job table memory
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = best_slot;
    mem_wdata = {best_prio, best_arr, best_len, rem_dec};
    if (ld_go) begin
      mem_we    = 1'b1;
      mem_waddr = ld_slot;
      mem_wdata = {PRIO_BITS'(priority_level_i), TIME_BITS'(arrival_time_i), ld_len, ld_rem};
    end else if (upd_go && found && !done) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_issue) begin
      rd_data_q <= mem_q[idx_q[SLOT_W-1:0]];
    end
  end

  assign rd_rem  = rd_data_q[REM_LO +: TIME_BITS];
  assign rd_len  = rd_data_q[LEN_LO +: TIME_BITS];
  assign rd_arr  = rd_data_q[ARR_LO +: TIME_BITS];
  assign rd_prio = rd_data_q[PRI_LO +: PRIO_BITS];

  // admitted jobs stay admitted; others join once their arrival has come
  assign cand_elig = rd_vld_q && valid_q[rd_idx_q] &&
                     (adm_q[rd_idx_q] || (rd_arr <= time_q));

  assign sel_ctl.clear    = tick_go;
  assign sel_ctl.cand_vld = cand_elig;

  pps_select #(
    .MAX_JOBS  (MAX_JOBS),
    .TIME_BITS (TIME_BITS),
    .PRIO_BITS (PRIO_BITS)
  ) u_select (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (sel_ctl),
    .cand_slot_i (rd_idx_q),
    .cand_prio_i (rd_prio),
    .cand_arr_i  (rd_arr),
    .cand_len_i  (rd_len),
    .cand_rem_i  (rd_rem),
    .found_o     (found),
    .best_slot_o (best_slot),
    .best_prio_o (best_prio),
    .best_arr_o  (best_arr),
    .best_len_o  (best_len),
    .best_rem_o  (best_rem)
  );

  // update of the picked job
  assign rem_dec  = (best_rem != '0) ? best_rem - TIME_BITS'(1) : best_rem;
  assign done     = found && (rem_dec == '0);
  assign fin_time = (time_q == '1) ? time_q : time_q + TIME_BITS'(1);
  assign turn     = fin_time - best_arr;
  assign wait_t   = (turn > best_len) ? turn - best_len : '0;

  always_comb begin
    clr_vec = '0;
    if (done) begin
      clr_vec[best_slot] = 1'b1;
    end
  end

  assign valid_after = valid_q & ~clr_vec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      adm_q   <= '0;
      time_q  <= '0;
    end else begin
      if (ld_go) begin
        valid_q[ld_slot] <= 1'b1;
        adm_q[ld_slot]   <= 1'b0;
      end
      if (cand_elig) begin
        adm_q[rd_idx_q] <= 1'b1;
      end
      if (upd_go) begin
        valid_q <= valid_after;
        adm_q   <= adm_q & ~clr_vec;
        time_q  <= fin_time;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (upd_go) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_go) begin
      slot_time_q   <= TIME_IO_W'(time_q);
      busy_q        <= found;
      running_job_q <= found ? SLOT_IO_W'(best_slot) : '0;
      job_done_q    <= done;
      turnaround_q  <= done ? TIME_IO_W'(turn) : '0;
      waiting_q     <= done ? TIME_IO_W'(wait_t) : '0;
      all_done_q    <= ~|valid_after;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign slot_time_o   = slot_time_q;
  assign busy_res_o    = busy_q;
  assign running_job_o = running_job_q;
  assign job_done_o    = job_done_q;
  assign turnaround_o  = turnaround_q;
  assign waiting_o     = waiting_q;
  assign all_done_o    = all_done_q;

  // checks
  a_res_from_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_UPD))
    else $error("result register loaded outside the update step");

  a_time_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_UPD) |=> $stable(time_q))
    else $error("time moved outside the update step");

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && job_done_q) |-> busy_q)
    else $error("job reported done on an idle tick");

  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !busy_q) |-> (turnaround_q == '0 && waiting_q == '0))
    else $error("idle tick carries job timing");

  a_no_load_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> !mem_we)
    else $error("table written during a scan");

endmodule

@@ test/preemptive_priority_scheduler_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_unit_tb
// Self-checking bench: load and tick requests go in through a valid/ready
// port; every tick result is compared field by field with a model of the
// job table kept here or with a typed row's result. Directed rows come first,
// then random requests, mostly job bursts, under three idling mixes.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_unit_tb;
  import pps_pkg::*;

  localparam int NJOBS = MAX_JOBS_DEF;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam logic [TIME_IO_W-1:0] TIME_TOP = '1;

  typedef struct packed {
    logic                 op;
    logic [SLOT_IO_W-1:0] slot;
    logic [TIME_IO_W-1:0] arrival;
    logic [TIME_IO_W-1:0] length;
    logic [PRIO_IO_W-1:0] prio;
  } sched_req_t;

  typedef struct packed {
    logic [TIME_IO_W-1:0] slot_time;
    logic                 busy;
    logic [SLOT_IO_W-1:0] job;
    logic                 done;
    logic [TIME_IO_W-1:0] turnaround;
    logic [TIME_IO_W-1:0] waiting;
    logic                 all_done;
  } tick_result_t;

  typedef struct packed {
    sched_req_t   req;
    logic         typed;
    tick_result_t want;
  } stim_row_t;

  localparam tick_result_t IDLE_AT_RESET =
    {16'd0, 1'b0, 3'd0, 1'b0, 16'd0, 16'd0, 1'b1};

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic                 opcode_i;
  logic [SLOT_IO_W-1:0] job_slot_i;
  logic [TIME_IO_W-1:0] arrival_time_i;
  logic [TIME_IO_W-1:0] run_length_i;
  logic [PRIO_IO_W-1:0] priority_level_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [TIME_IO_W-1:0] slot_time_o;
  logic                 busy_res_o;
  logic [SLOT_IO_W-1:0] running_job_o;
  logic                 job_done_o;
  logic [TIME_IO_W-1:0] turnaround_o;
  logic [TIME_IO_W-1:0] waiting_o;
  logic                 all_done_o;

  // job table model
  logic                 tbl_live     [NJOBS];
  logic                 tbl_admitted [NJOBS];
  logic [TIME_IO_W-1:0] tbl_arrival  [NJOBS];
  logic [TIME_IO_W-1:0] tbl_length   [NJOBS];
  logic [TIME_IO_W-1:0] tbl_left     [NJOBS];
  logic [PRIO_IO_W-1:0] tbl_prio     [NJOBS];
  logic [TIME_IO_W-1:0] sched_now;

  tick_result_t expected_ticks [$];
  stim_row_t    stim_rows [$];
  tick_result_t mon_want;

  int src_idle_pct = 30;
  int snk_idle_pct = 54;
  int n_errors = 0;
  int n_loads = 0;
  int n_ticks = 0;
  int n_completed = 0;
  int n_idle = 0;
  int n_all_done = 0;
  int cycle_count = 0;

  preemptive_priority_scheduler_unit u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .opcode_i         (opcode_i),
    .job_slot_i       (job_slot_i),
    .arrival_time_i   (arrival_time_i),
    .run_length_i     (run_length_i),
    .priority_level_i (priority_level_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .slot_time_o      (slot_time_o),
    .busy_res_o       (busy_res_o),
    .running_job_o    (running_job_o),
    .job_done_o       (job_done_o),
    .turnaround_o     (turnaround_o),
    .waiting_o        (waiting_o),
    .all_done_o       (all_done_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic void sched_load(input sched_req_t req);
    tbl_live[req.slot]     = 1'b1;
    tbl_admitted[req.slot] = 1'b0;
    tbl_arrival[req.slot]  = req.arrival;
    tbl_length[req.slot]   = req.length;
    // a zero length job still takes one time unit
    tbl_left[req.slot]     = (req.length == '0) ? 16'd1 : req.length;
    tbl_prio[req.slot]     = req.prio;
  endfunction

  function automatic tick_result_t sched_tick();
    tick_result_t r;
    int i;
    int pick;
    logic [TIME_IO_W-1:0] fin;
    r = '0;
    pick = -1;
    r.slot_time = sched_now;
    for (i = 0; i < NJOBS; i++) begin
      if (tbl_live[i] && !tbl_admitted[i] && tbl_arrival[i] <= sched_now) begin
        tbl_admitted[i] = 1'b1;
      end
    end
    // lowest priority value, then earliest arrival, then lowest slot
    for (i = 0; i < NJOBS; i++) begin
      if (tbl_live[i] && tbl_admitted[i]) begin
        if (pick < 0) begin
          pick = i;
        end else if (tbl_prio[i] < tbl_prio[pick] ||
                     (tbl_prio[i] == tbl_prio[pick] &&
                      tbl_arrival[i] < tbl_arrival[pick])) begin
          pick = i;
        end
      end
    end
    if (pick >= 0) begin
      r.busy = 1'b1;
      r.job = pick[SLOT_IO_W-1:0];
      if (tbl_left[pick] != '0) begin
        tbl_left[pick] = tbl_left[pick] - 16'd1;
      end
      if (tbl_left[pick] == '0) begin
        fin = (sched_now == TIME_TOP) ? sched_now : sched_now + 16'd1;
        r.done = 1'b1;
        r.turnaround = fin - tbl_arrival[pick];
        r.waiting = (r.turnaround > tbl_length[pick]) ?
                    r.turnaround - tbl_length[pick] : '0;
        tbl_live[pick] = 1'b0;
        tbl_admitted[pick] = 1'b0;
        n_completed++;
      end
    end else begin
      n_idle++;
    end
    r.all_done = 1'b1;
    for (i = 0; i < NJOBS; i++) begin
      if (tbl_live[i]) begin
        r.all_done = 1'b0;
      end
    end
    if (r.all_done) begin
      n_all_done++;
    end
    if (sched_now != TIME_TOP) begin
      sched_now = sched_now + 16'd1;
    end
    return r;
  endfunction

  task automatic send_request(input sched_req_t req, input logic typed,
                              input tick_result_t want);
    tick_result_t predicted;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    opcode_i         <= req.op;
    job_slot_i       <= req.slot;
    arrival_time_i   <= req.arrival;
    run_length_i     <= req.length;
    priority_level_i <= req.prio;
    do @(posedge clk_i); while (!in_ready_o);
    if (req.op == OP_TICK) begin
      n_ticks++;
      predicted = sched_tick();
      expected_ticks = {expected_ticks, (typed ? want : predicted)};
    end else begin
      n_loads++;
      sched_load(req);
    end
  endtask

  task automatic issue(input logic op, input logic [SLOT_IO_W-1:0] slot,
                       input logic [TIME_IO_W-1:0] arr,
                       input logic [TIME_IO_W-1:0] len,
                       input logic [PRIO_IO_W-1:0] prio);
    sched_req_t req;
    req = {op, slot, arr, len, prio};
    send_request(req, 1'b0, '0);
  endtask

  function automatic void add_row(input logic op, input logic [SLOT_IO_W-1:0] slot,
                                  input logic [TIME_IO_W-1:0] arr,
                                  input logic [TIME_IO_W-1:0] len,
                                  input logic [PRIO_IO_W-1:0] prio,
                                  input logic typed, input tick_result_t want);
    stim_row_t row;
    row.req = {op, slot, arr, len, prio};
    row.typed = typed;
    row.want = want;
    stim_rows = {stim_rows, row};
  endfunction

  task automatic walk_rows();
    stim_row_t row;
    while (stim_rows.size() != 0) begin
      row = stim_rows.pop_front();
      send_request(row.req, row.typed, row.want);
    end
  endtask

  // sender holds off until every tick result is back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic run_random(input int n_items);
    int sent;
    int nload;
    int k;
    int span;
    int slot;
    logic [TIME_IO_W-1:0] len;
    logic [PRIO_IO_W-1:0] prio;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 80) begin
        // burst of near-term jobs, then enough ticks to run them out
        nload = ($urandom_range(0, 2) == 0) ? NJOBS : $urandom_range(1, NJOBS);
        span = 0;
        for (k = 0; k < nload; k++) begin
          slot = (nload == NJOBS) ? k : $urandom_range(0, NJOBS - 1);
          len = ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom_range(1, 5));
          prio = $urandom_range(0, 1) ? 8'($urandom()) : 8'($urandom_range(0, 2));
          issue(OP_LOAD, 3'(slot), sched_now + 16'($urandom_range(0, 4)), len, prio);
          span += (len == '0) ? 1 : int'(len);
        end
        span += 4 + $urandom_range(0, 3);
        sent += nload + span;
        for (k = 0; k < span; k++) begin
          if ($urandom_range(0, 19) == 0) begin
            issue(OP_LOAD, 3'($urandom_range(0, NJOBS - 1)),
                  sched_now + 16'($urandom_range(0, 2)),
                  16'($urandom_range(1, 3)), 8'($urandom()));
            sent++;
          end
          issue(OP_TICK, 3'($urandom()), 16'($urandom()), 16'($urandom()),
                8'($urandom()));
        end
      end else begin
        issue(1'($urandom()), 3'($urandom()), 16'($urandom()), 16'($urandom()),
              8'($urandom()));
        sent++;
      end
    end
  endtask

  task automatic check_field(input string name, input int unsigned exp_val,
                             input int unsigned act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name,
               exp_val, act_val);
      n_errors++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_ticks.size() == 0) begin
        $display("%0t: unexpected result, expected none actual slot_time %0h",
                 $time, slot_time_o);
        n_errors++;
      end else begin
        mon_want = expected_ticks.pop_front();
        check_field("slot_time", mon_want.slot_time, slot_time_o);
        check_field("busy_res", mon_want.busy, busy_res_o);
        check_field("running_job", mon_want.job, running_job_o);
        check_field("job_done", mon_want.done, job_done_o);
        check_field("turnaround", mon_want.turnaround, turnaround_o);
        check_field("waiting", mon_want.waiting, waiting_o);
        check_field("all_done", mon_want.all_done, all_done_o);
      end
    end
    out_ready_i <= ($urandom_range(0, 99) >= snk_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("preemptive_priority_scheduler_unit regression: fail");
      $finish;
    end
  end

  initial begin
    int k;
    rst_ni           <= 1'b0;
    in_valid_i       <= 1'b0;
    opcode_i         <= OP_LOAD;
    job_slot_i       <= '0;
    arrival_time_i   <= '0;
    run_length_i     <= '0;
    priority_level_i <= '0;
    out_ready_i      <= 1'b0;
    for (k = 0; k < NJOBS; k++) begin
      tbl_live[k] = 1'b0;
      tbl_admitted[k] = 1'b0;
    end
    sched_now = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    add_row(OP_TICK, 3'd0, 16'd0, 16'd0, 8'd0, 1'b1, IDLE_AT_RESET);
    add_row(OP_LOAD, 3'd7, 16'd0, 16'd1, 8'd255, 1'b0, '0);
    add_row(OP_LOAD, 3'd0, 16'd1, 16'd2, 8'd0, 1'b0, '0);
    add_row(OP_TICK, 3'd0, 16'd0, 16'd0, 8'd0, 1'b0, '0);
    // zero length job, wins the priority tie on earlier arrival
    add_row(OP_LOAD, 3'd3, 16'd0, 16'd0, 8'd0, 1'b0, '0);
    add_row(OP_TICK, 3'd0, 16'd0, 16'd0, 8'd0, 1'b0, '0);
    add_row(OP_TICK, 3'd0, 16'd0, 16'd0, 8'd0, 1'b0, '0);
    // same priority and arrival as slot 7, lower slot goes first
    add_row(OP_LOAD, 3'd2, 16'd0, 16'd1, 8'd255, 1'b0, '0);
    add_row(OP_LOAD, 3'd5, 16'd4, 16'd1, 8'd255, 1'b0, '0);
    add_row(OP_TICK, 3'd0, 16'd0, 16'd0, 8'd0, 1'b0, '0);
    add_row(OP_TICK, 3'd0, 16'd0, 16'd0, 8'd0, 1'b0, '0);
    add_row(OP_TICK, 3'd0, 16'd0, 16'd0, 8'd0, 1'b0, '0);
    add_row(OP_TICK, 3'd0, 16'd0, 16'd0, 8'd0, 1'b0, '0);
    add_row(OP_LOAD, 3'd1, 16'hFFFF, 16'hFFFF, 8'd128, 1'b0, '0);
    add_row(OP_LOAD, 3'd4, 16'd8, 16'd3, 8'd1, 1'b0, '0);
    add_row(OP_TICK, 3'd0, 16'd0, 16'd0, 8'd0, 1'b0, '0);
    // higher priority arrival preempts the running job
    add_row(OP_LOAD, 3'd6, 16'd9, 16'd1, 8'd0, 1'b0, '0);
    add_row(OP_TICK, 3'd0, 16'd0, 16'd0, 8'd0, 1'b0, '0);
    add_row(OP_TICK, 3'd0, 16'd0, 16'd0, 8'd0, 1'b0, '0);
    add_row(OP_TICK, 3'd0, 16'd0, 16'd0, 8'd0, 1'b0, '0);
    // overwrite of the far future job
    add_row(OP_LOAD, 3'd1, 16'd0, 16'd1, 8'd170, 1'b0, '0);
    add_row(OP_TICK, 3'd0, 16'd0, 16'd0, 8'd0, 1'b0, '0);
    walk_rows();

    run_random(310);
    drain();
    src_idle_pct = 54;
    snk_idle_pct = 30;
    run_random(310);
    drain();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    run_random(310);
    drain();

    repeat (4 * (NJOBS + 3)) @(posedge clk_i);
    $display("run covered %0d loads and %0d ticks: %0d jobs completed, %0d idle ticks",
             n_loads, n_ticks, n_completed, n_idle);
    $display("%0d results with the table empty, time counter ended at %0h, %0d mismatches",
             n_all_done, sched_now, n_errors);
    if (n_errors == 0) begin
      $display("preemptive_priority_scheduler_unit regression: pass");
    end else begin
      $display("preemptive_priority_scheduler_unit regression: fail");
    end
    $finish;
  end

endmodule
